### hw/rtl/uqve_pkg.sv
`default_nettype none

package uqve_pkg;

   // Scanner phase codes
   localparam logic [1:0] PH_SEARCH    = 2'd0;
   localparam logic [1:0] PH_AFTER_KEY = 2'd1;
   localparam logic [1:0] PH_VALUE     = 2'd2;
   localparam logic [1:0] PH_DONE      = 2'd3;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_KEY_FIRST = 2'd0;
   localparam logic [1:0] CSR_KEY_LAST  = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN   = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_QMARK = 8'h3f;

   localparam int KEY_POS_BITS = 5;

   // Scanner state apart from the value counter
   typedef struct packed {
      logic [1:0]              phase;
      logic [KEY_POS_BITS-1:0] key_pos;
      logic [7:0]              prev_byte;
   } scan_state_type;

   // One result item apart from the length
   typedef struct packed {
      logic       valid;
      logic [7:0] out_char;
      logic       char_valid;
      logic       key_found;
      logic       last;
   } scan_result_type;

endpackage

`default_nettype wire

### hw/rtl/uqve_step.sv
`default_nettype none

module uqve_step #(
   parameter int LENGTH_BITS = 10
) (
   input  wire uqve_pkg::scan_state_type       cur_state,
   input  wire logic [LENGTH_BITS-1:0]        cur_count,
   input  wire logic [7:0]                    in_char,
   input  wire logic [7:0]                    key_byte,
   input  wire logic [uqve_pkg::KEY_POS_BITS-1:0] eff_key_len,
   output uqve_pkg::scan_state_type            nxt_state,
   output logic      [LENGTH_BITS-1:0]        nxt_count,
   output uqve_pkg::scan_result_type           result,
   output logic      [LENGTH_BITS-1:0]        result_length
);
   import uqve_pkg::*;

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   logic                    line_end;
   logic                    value_end;
   logic                    sep_before;
   logic [KEY_POS_BITS-1:0] key_pos_inc;

   assign line_end    = (in_char == CH_NUL) || (in_char == CH_CR) || (in_char == CH_LF);
   assign value_end   = line_end || (in_char == CH_SPACE) || (in_char == CH_AMP);
   assign sep_before  = (cur_state.prev_byte == CH_QMARK) || (cur_state.prev_byte == CH_AMP);
   assign key_pos_inc = cur_state.key_pos + KEY_POS_BITS'(1);

   always_comb begin
      nxt_state     = cur_state;
      nxt_count     = cur_count;
      result        = '0;
      result_length = '0;
      unique case (cur_state.phase)
         PH_SEARCH: begin
            if (line_end) begin
               result.valid = 1'b1;
               result.last  = 1'b1;
               nxt_state    = '0;
               nxt_count    = '0;
            end else if (in_char == key_byte) begin
               // key start needs a separator before it; else skip the byte
               if ((cur_state.key_pos != '0) || sep_before) begin
                  if (key_pos_inc >= eff_key_len) begin
                     nxt_state.key_pos = '0;
                     nxt_state.phase   = PH_AFTER_KEY;
                  end else begin
                     nxt_state.key_pos   = key_pos_inc;
                     nxt_state.prev_byte = in_char;
                  end
               end
            end else begin
               nxt_state.key_pos   = '0;
               nxt_state.prev_byte = in_char;
            end
         end
         PH_AFTER_KEY: begin
            if (line_end) begin
               result.valid = 1'b1;
               result.last  = 1'b1;
               nxt_state    = '0;
               nxt_count    = '0;
            end else if (in_char == CH_EQ) begin
               nxt_state.phase = PH_VALUE;
               nxt_count       = '0;
            end else begin
               nxt_state.prev_byte = in_char;
               nxt_state.phase     = PH_SEARCH;
            end
         end
         PH_VALUE: begin
            if (value_end) begin
               result.valid     = 1'b1;
               result.key_found = 1'b1;
               result.last      = 1'b1;
               result_length    = cur_count;
               if (line_end) begin
                  nxt_state = '0;
                  nxt_count = '0;
               end else begin
                  nxt_state.phase = PH_DONE;
               end
            end else begin
               if (cur_count != COUNT_MAX) begin
                  nxt_count = cur_count + LENGTH_BITS'(1);
               end
               result.valid      = 1'b1;
               result.out_char   = in_char;
               result.char_valid = 1'b1;
            end
         end
         PH_DONE: begin
            // drop bytes until the line ends
            if (line_end) begin
               nxt_state = '0;
               nxt_count = '0;
            end
         end
         default: begin
            nxt_state = '0;
            nxt_count = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/url_query_value_extractor_unit.sv
// URL query value extractor.
// Feed a request line one byte per item on the req_ channel (valid/ready).
// The block looks for "?key=" or "&key=" where the key is set through the
// csr_ channel (index 0: key bytes 0-7, index 1: key bytes 8-15, index 2:
// key length). Each value byte comes out as an rsp_ item with
// rsp_char_valid set; a final item with rsp_last set reports rsp_key_found
// and rsp_value_length (saturating). NUL, CR or LF ends the line and rearms
// the search; a line without the key gives one final item, not found.
// An accepted byte goes into the input register, and its result item into
// the result register. Throughput: one byte per cycle while the receiver
// takes results, since every byte is handled by one pass of compare logic
// between the input register and the result register. When the receiver
// stalls, the result register holds its item; one more byte may wait in the
// input register, after which req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, clears the key
// to zero with length one and puts the scanner back to searching.
// Write the key registers only while the block is idle; csr_ready is
// always high.

`default_nettype none

module url_query_value_extractor_unit #(
   parameter int MAX_KEY_LEN = 16,
   parameter int LENGTH_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request bytes
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_in_char,
   // result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_char_valid,
   output logic                        rsp_key_found,
   output logic [LENGTH_BITS-1:0]      rsp_value_length,
   output logic                        rsp_last,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [63:0]            csr_data
);
   import uqve_pkg::*;

   localparam logic [KEY_POS_BITS-1:0] MAX_LEN = KEY_POS_BITS'(MAX_KEY_LEN);

   // key registers
   logic [63:0]             key_first_ff;
   logic [63:0]             key_last_ff;
   logic [4:0]              key_len_ff;
   logic [KEY_POS_BITS-1:0] eff_key_len;
   logic [127:0]            key_all;
   logic [7:0]              key_byte;

   // input register
   logic                    in_valid_ff;
   logic [7:0]              in_char_ff;

   // scanner state
   scan_state_type          state_ff;
   scan_state_type          state_in;
   logic [LENGTH_BITS-1:0]  count_ff;
   logic [LENGTH_BITS-1:0]  count_in;

   // result register
   scan_result_type         step_result;
   logic [LENGTH_BITS-1:0]  step_length;
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_char_ff;
   logic                    rsp_char_valid_ff;
   logic                    rsp_found_ff;
   logic [LENGTH_BITS-1:0]  rsp_length_ff;
   logic                    rsp_last_ff;

   logic                    advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_first_ff <= '0;
         key_last_ff  <= '0;
         key_len_ff   <= 5'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_FIRST: key_first_ff <= csr_data;
            CSR_KEY_LAST:  key_last_ff  <= csr_data;
            CSR_KEY_LEN:   key_len_ff   <= csr_data[4:0];
            default:       ;
         endcase
      end
   end

   // length zero acts as one, anything past the maximum as the maximum
   always_comb begin
      if (key_len_ff == '0) begin
         eff_key_len = KEY_POS_BITS'(1);
      end else if (key_len_ff > MAX_LEN) begin
         eff_key_len = MAX_LEN;
      end else begin
         eff_key_len = key_len_ff;
      end
   end

   assign key_all  = {key_last_ff, key_first_ff};
   assign key_byte = key_all[8*state_ff.key_pos[3:0] +: 8];

   // Process the held byte whenever the result register is free or emptying.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_in_char;
      end
   end

   uqve_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .cur_state     (state_ff),
      .cur_count     (count_ff),
      .in_char       (in_char_ff),
      .key_byte      (key_byte),
      .eff_key_len   (eff_key_len),
      .nxt_state     (state_in),
      .nxt_count     (count_in),
      .result        (step_result),
      .result_length (step_length)
   );

   // Advance the scanner state once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Result register: load on a byte that yields an item, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && step_result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.valid) begin
         rsp_char_ff       <= step_result.out_char;
         rsp_char_valid_ff <= step_result.char_valid;
         rsp_found_ff      <= step_result.key_found;
         rsp_length_ff     <= step_length;
         rsp_last_ff       <= step_result.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_char_valid   = rsp_char_valid_ff;
   assign rsp_key_found    = rsp_found_ff;
   assign rsp_value_length = rsp_length_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire
